[src/smx_pkg.sv]
// Shared package for the stack machine executor.
// Holds stack sizing, opcode and status codes, and the controller/datapath bundles.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package smx_pkg;

	// Stack sizing
	localparam int STACK_DEPTH = 128;
	localparam int AW          = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	// Opcodes
	localparam logic [3:0] OP_PUSH = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_SUB  = 4'd2;
	localparam logic [3:0] OP_MUL  = 4'd3;
	localparam logic [3:0] OP_DIV  = 4'd4;
	localparam logic [3:0] OP_LT   = 4'd5;
	localparam logic [3:0] OP_LE   = 4'd6;
	localparam logic [3:0] OP_GT   = 4'd7;
	localparam logic [3:0] OP_GE   = 4'd8;
	localparam logic [3:0] OP_EQ   = 4'd9;
	localparam logic [3:0] OP_DUP  = 4'd10;
	localparam logic [3:0] OP_DROP = 4'd11;
	localparam logic [3:0] OP_SWAP = 4'd12;
	localparam logic [3:0] OP_EMIT = 4'd13;

	// Result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	// Top-of-stack load source
	localparam logic [2:0] TOS_HOLD = 3'd0;
	localparam logic [2:0] TOS_LIT  = 3'd1;
	localparam logic [2:0] TOS_RD   = 3'd2;
	localparam logic [2:0] TOS_ALU  = 3'd3;
	localparam logic [2:0] TOS_QUOT = 3'd4;

	// Stack pointer update
	localparam logic [1:0] SPU_HOLD = 2'd0;
	localparam logic [1:0] SPU_INC  = 2'd1;
	localparam logic [1:0] SPU_DEC1 = 2'd2;
	localparam logic [1:0] SPU_DEC2 = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       latch_in;   // capture opcode and literal, clear result flags
		logic       set_status;
		logic [1:0] status;
		logic       set_emit;   // capture low byte of top as emitted character
		logic       mem_wr;     // write top register into the stack memory
		logic       wsel_m2;    // write address: 1 = sp-2, 0 = sp-1
		logic       rsel_m3;    // read address: 1 = sp-3, 0 = sp-2
		logic [2:0] tos_sel;
		logic [1:0] sp_upd;
		logic       div_start;
		logic       out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [3:0] op;
		logic       sp_zero;
		logic       sp_lt2;
		logic       sp_gt1;
		logic       sp_gt2;
		logic       sp_full;
		logic       rd_zero;
		logic       div_done;
	} stat_t;

endpackage

[src/stack_machine_executor_core.sv]
// Top level of the stack machine executor: one compiled word in, one result out.
// Instantiates smx_ctrl and smx_dpath (which holds smx_div); depends on smx_pkg.
//
//  channel  dir  tdata                                           tuser
//  s_*      in   literal_value[31:0]                             opcode[3:0]
//  m_*      out  emit_char[7:0] stack_depth[15:8] top[47:16]     status[1:0] emit_valid[2]
//
// Push, dup, unused opcodes, decode errors and a drop or emit emptying the stack go
// from S_DEC to S_DONE; drop and emit add S_LDTOP, binary words and swap S_RD2 (one
// stack memory read), a divide by zero also S_LDTOP with entries left, a divide S_DIV.
// Reset empties the stack at once; memory contents stay undefined until written.
// A word is accepted while the previous result waits in the output register; the
// block holds in its final state while m_tready stays low and that register is full.
`timescale 1ns / 1ps

module stack_machine_executor_core
	import smx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // literal_value[31:0]
	input  logic [3:0]  s_tuser,  // opcode[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // emit_char[7:0], stack_depth[15:8], top_of_stack[47:16]
	output logic [2:0]  m_tuser   // status[1:0], emit_valid[2]
);

	cmd_t  cmd;
	stat_t stat;

	logic [1:0]  status;
	logic        emit_valid;
	logic [7:0]  emit_char;
	logic [7:0]  stack_depth;
	logic [31:0] top_of_stack;

	smx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	smx_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_opcode      (s_tuser),
		.in_literal     (s_tdata),
		.out_status     (status),
		.out_emit_valid (emit_valid),
		.out_emit_char  (emit_char),
		.out_depth      (stack_depth),
		.out_top        (top_of_stack)
	);

	// Pack the result word
	assign m_tdata = {top_of_stack, stack_depth, emit_char};
	assign m_tuser = {emit_valid, status};

	// No word is taken in the cycle after one is accepted
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("word accepted on consecutive cycles");

	// An emitted character only comes with a clean status
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == ST_OK))
		else $error("emit reported together with an error status");

	// An empty stack reports a zero top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[15:8] == 8'd0)) |-> (m_tdata[47:16] == 32'd0))
		else $error("nonzero top reported for an empty stack");

	// The divider only starts from the operand read state and never on a zero divisor
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (!stat.rd_zero && (stat.op == OP_DIV)))
		else $error("divider started without a valid divisor");

endmodule

[src/smx_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Works on magnitudes and fixes the sign at the end.
// Depends on smx_pkg.
`timescale 1ns / 1ps

module smx_div
	import smx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] mag_q;

	logic [32:0] shifted;
	logic [33:0] diff;

	// Shift in the next dividend bit and try the subtraction
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = {1'b0, shifted} - {2'b00, mag_q};

	// Control: busy while the bit counter runs down, then flag done for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load magnitudes, then iterate
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31] ^ divisor[31];
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			mag_q <= divisor[31] ? (32'd0 - divisor) : divisor;
		end else if (busy_q) begin
			rem_q <= diff[33] ? shifted[31:0] : diff[31:0];
			quo_q <= {quo_q[30:0], ~diff[33]};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

[src/smx_dpath.sv]
// Datapath of the stack machine executor: stack memory, top-of-stack and
// pointer registers, ALU, divider and the output payload register.
// Depends on smx_pkg and smx_div.
`timescale 1ns / 1ps

module smx_dpath
	import smx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [3:0]  in_opcode,
	input  logic [31:0] in_literal,
	output logic [1:0]  out_status,
	output logic        out_emit_valid,
	output logic [7:0]  out_emit_char,
	output logic [7:0]  out_depth,
	output logic [31:0] out_top
);

	// Entries below the top live in memory; the top entry lives in tos_q
	logic [31:0] mem [STACK_DEPTH];

	logic [3:0]      op_q;
	logic [31:0]     lit_q;
	logic [SP_W-1:0] sp_q;
	logic [31:0]     tos_q;
	logic [31:0]     rd_q;
	logic [1:0]      status_q;
	logic            ev_q;
	logic [7:0]      ch_q;

	logic [SP_W-1:0] sp_m1;
	logic [SP_W-1:0] sp_m2;
	logic [SP_W-1:0] sp_m3;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [31:0]     alu_res;
	logic [31:0]     prod;
	logic            div_done;
	logic [31:0]     quot;

	assign sp_m1 = sp_q - SP_W'(1);
	assign sp_m2 = sp_q - SP_W'(2);
	assign sp_m3 = sp_q - SP_W'(3);
	assign waddr = cmd.wsel_m2 ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
	assign raddr = cmd.rsel_m3 ? sp_m3[AW-1:0] : sp_m2[AW-1:0];

	// Stack memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[waddr] <= tos_q;
		end
		rd_q <= mem[raddr];
	end

	// ALU: top op second, second comes from the memory read register
	assign prod = tos_q * rd_q;
	always_comb begin
		case (op_q)
			OP_ADD:  alu_res = tos_q + rd_q;
			OP_SUB:  alu_res = tos_q - rd_q;
			OP_MUL:  alu_res = prod;
			OP_LT:   alu_res = {31'd0, signed'(tos_q) <  signed'(rd_q)};
			OP_LE:   alu_res = {31'd0, signed'(tos_q) <= signed'(rd_q)};
			OP_GT:   alu_res = {31'd0, signed'(tos_q) >  signed'(rd_q)};
			OP_GE:   alu_res = {31'd0, signed'(tos_q) >= signed'(rd_q)};
			default: alu_res = {31'd0, tos_q == rd_q};
		endcase
	end

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (tos_q),
		.divisor  (rd_q),
		.done     (div_done),
		.quotient (quot)
	);

	// Stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			case (cmd.sp_upd)
				SPU_INC:  sp_q <= sp_q + SP_W'(1);
				SPU_DEC1: sp_q <= sp_m1;
				SPU_DEC2: sp_q <= sp_m2;
				default:  sp_q <= sp_q;
			endcase
		end
	end

	// Top of stack, input capture and result flags
	always_ff @(posedge clk) begin
		case (cmd.tos_sel)
			TOS_LIT:  tos_q <= lit_q;
			TOS_RD:   tos_q <= rd_q;
			TOS_ALU:  tos_q <= alu_res;
			TOS_QUOT: tos_q <= quot;
			default:  tos_q <= tos_q;
		endcase
		if (cmd.latch_in) begin
			op_q     <= in_opcode;
			lit_q    <= in_literal;
			status_q <= ST_OK;
			ev_q     <= 1'b0;
			ch_q     <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.set_emit) begin
				ev_q <= 1'b1;
				ch_q <= tos_q[7:0];
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status     <= status_q;
			out_emit_valid <= ev_q;
			out_emit_char  <= ch_q;
			out_depth      <= 8'(sp_q);
			out_top        <= (sp_q == '0) ? 32'd0 : tos_q;
		end
	end

	// Status to the controller
	assign stat.op       = op_q;
	assign stat.sp_zero  = (sp_q == '0);
	assign stat.sp_lt2   = (sp_q < SP_W'(2));
	assign stat.sp_gt1   = (sp_q > SP_W'(1));
	assign stat.sp_gt2   = (sp_q > SP_W'(2));
	assign stat.sp_full  = (sp_q == SP_W'(STACK_DEPTH));
	assign stat.rd_zero  = (rd_q == 32'd0);
	assign stat.div_done = div_done;

endmodule

[src/smx_ctrl.sv]
// Controller of the stack machine executor: sequences each word through
// decode, operand read, divide, top reload, result hand-off; owns both handshakes.
// Depends on smx_pkg.
`timescale 1ns / 1ps

module smx_ctrl
	import smx_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_RD2   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_LDTOP = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_DONE;
				case (stat.op)
					OP_PUSH: begin
						if (stat.sp_full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_OVER;
						end else begin
							cmd.mem_wr  = !stat.sp_zero;
							cmd.tos_sel = TOS_LIT;
							cmd.sp_upd  = SPU_INC;
						end
					end
					OP_DUP: begin
						if (stat.sp_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_UNDER;
						end else if (stat.sp_full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_OVER;
						end else begin
							cmd.mem_wr = 1'b1;
							cmd.sp_upd = SPU_INC;
						end
					end
					OP_DROP, OP_EMIT: begin
						if (stat.sp_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_UNDER;
						end else begin
							cmd.set_emit = (stat.op == OP_EMIT);
							cmd.sp_upd   = SPU_DEC1;
							// fetch the entry that becomes the new top
							if (stat.sp_gt1) begin
								state_d = S_LDTOP;
							end
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ,
					OP_SWAP: begin
						if (stat.sp_lt2) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_UNDER;
						end else begin
							state_d = S_RD2;
						end
					end
					default: ;
				endcase
			end
			S_RD2: begin
				state_d = S_DONE;
				case (stat.op)
					OP_SWAP: begin
						cmd.mem_wr  = 1'b1;
						cmd.wsel_m2 = 1'b1;
						cmd.tos_sel = TOS_RD;
					end
					OP_DIV: begin
						if (stat.rd_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_DIVZ;
							cmd.sp_upd     = SPU_DEC2;
							cmd.rsel_m3    = 1'b1;
							if (stat.sp_gt2) begin
								state_d = S_LDTOP;
							end
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					default: begin
						cmd.tos_sel = TOS_ALU;
						cmd.sp_upd  = SPU_DEC1;
					end
				endcase
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.tos_sel = TOS_QUOT;
					cmd.sp_upd  = SPU_DEC1;
					state_d     = S_DONE;
				end
			end
			S_LDTOP: begin
				cmd.tos_sel = TOS_RD;
				state_d     = S_DONE;
			end
			S_DONE: begin
				// hand off the result and take the next word in the same cycle
				if (out_free) begin
					cmd.out_load = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.latch_in = 1'b1;
						state_d      = S_DEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[tb/smx_result_checker.sv]
// Result checker for the stack machine executor: watches both stream channels,
// keeps its own copy of the data stack and compares every result word in order.
// Depends on smx_pkg for stack sizing, opcode and status codes.
`timescale 1ns / 1ps

module smx_result_checker
	import smx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // literal_value[31:0]
	input  logic [3:0]  s_tuser,   // opcode[3:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // emit_char[7:0], stack_depth[15:8], top_of_stack[47:16]
	input  logic [2:0]  m_tuser,   // status[1:0], emit_valid[2]
	output int          mismatches,
	output int          pending,
	output int          model_depth,
	output int          words_seen,
	output int          results_seen,
	output int          underflows,
	output int          overflows,
	output int          div_zeros,
	output int          emits
);

	typedef struct packed {
		logic [1:0]  status;
		logic        emit_valid;
		logic [7:0]  emit_char;
		logic [7:0]  depth;
		logic [31:0] top;
	} word_result_t;

	logic [31:0]  data_stack [STACK_DEPTH];
	int           stack_ptr;
	word_result_t expected_results [$];

	initial begin
		stack_ptr    = 0;
		mismatches   = 0;
		pending      = 0;
		model_depth  = 0;
		words_seen   = 0;
		results_seen = 0;
		underflows   = 0;
		overflows    = 0;
		div_zeros    = 0;
		emits        = 0;
	end

	// Signed division truncated toward zero, done on magnitudes
	function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] mag_a, mag_b, q;
		mag_a = a[31] ? -a : a;
		mag_b = b[31] ? -b : b;
		q     = mag_a / mag_b;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	// Top (a) op second (b), wrapped to 32 bits
	function automatic logic [31:0] binary_value(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		case (op)
			OP_ADD:  return a + b;
			OP_SUB:  return a - b;
			OP_MUL:  return a * b;
			OP_DIV:  return trunc_quotient(a, b);
			OP_LT:   return {31'b0, $signed(a) <  $signed(b)};
			OP_LE:   return {31'b0, $signed(a) <= $signed(b)};
			OP_GT:   return {31'b0, $signed(a) >  $signed(b)};
			OP_GE:   return {31'b0, $signed(a) >= $signed(b)};
			default: return {31'b0, a == b};
		endcase
	endfunction

	// Run one word against the stack copy and build the result it should give
	task automatic execute_word(input logic [3:0] op, input logic [31:0] lit,
			output word_result_t r);
		logic [31:0] a, b, t;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_PUSH: begin
				if (stack_ptr >= STACK_DEPTH) begin
					r.status = ST_OVER;
				end else begin
					data_stack[stack_ptr] = lit;
					stack_ptr++;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ: begin
				if (stack_ptr < 2) begin
					r.status = ST_UNDER;
				end else begin
					a = data_stack[stack_ptr - 1];
					b = data_stack[stack_ptr - 2];
					if (op == OP_DIV && b == 32'd0) begin
						stack_ptr -= 2;
						r.status = ST_DIVZ;
					end else begin
						data_stack[stack_ptr - 2] = binary_value(op, a, b);
						stack_ptr--;
					end
				end
			end
			OP_DUP: begin
				if (stack_ptr < 1) begin
					r.status = ST_UNDER;
				end else if (stack_ptr >= STACK_DEPTH) begin
					r.status = ST_OVER;
				end else begin
					data_stack[stack_ptr] = data_stack[stack_ptr - 1];
					stack_ptr++;
				end
			end
			OP_DROP: begin
				if (stack_ptr < 1)
					r.status = ST_UNDER;
				else
					stack_ptr--;
			end
			OP_SWAP: begin
				if (stack_ptr < 2) begin
					r.status = ST_UNDER;
				end else begin
					t = data_stack[stack_ptr - 1];
					data_stack[stack_ptr - 1] = data_stack[stack_ptr - 2];
					data_stack[stack_ptr - 2] = t;
				end
			end
			OP_EMIT: begin
				if (stack_ptr < 1) begin
					r.status = ST_UNDER;
				end else begin
					stack_ptr--;
					r.emit_valid = 1'b1;
					r.emit_char  = data_stack[stack_ptr][7:0];
				end
			end
			default: ;
		endcase
		r.depth = stack_ptr[7:0];
		r.top   = (stack_ptr != 0) ? data_stack[stack_ptr - 1] : 32'd0;

		// Tally the special outcomes
		if (r.status == ST_UNDER) underflows++;
		if (r.status == ST_OVER)  overflows++;
		if (r.status == ST_DIVZ)  div_zeros++;
		if (r.emit_valid)         emits++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %0d %s mismatch: expected %0h, got %0h",
					$realtime, results_seen, name, want, got);
		end
	endtask

	// Retire results first, then predict the word accepted at this edge
	always @(posedge clk) begin : monitor
		word_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word with none expected: tdata %0h tuser %0h",
							$realtime, m_tdata, m_tuser);
				end else begin
					want = expected_results.pop_front();
					check_field("status", {30'b0, want.status}, {30'b0, m_tuser[1:0]});
					check_field("emit_valid", {31'b0, want.emit_valid}, {31'b0, m_tuser[2]});
					check_field("emit_char", {24'b0, want.emit_char}, {24'b0, m_tdata[7:0]});
					check_field("stack_depth", {24'b0, want.depth}, {24'b0, m_tdata[15:8]});
					check_field("top_of_stack", want.top, m_tdata[47:16]);
				end
			end
			if (s_tvalid && s_tready) begin
				execute_word(s_tuser, s_tdata, want);
				expected_results.push_back(want);
				words_seen++;
			end
			pending     = expected_results.size();
			model_depth = stack_ptr;
		end
	end

endmodule

[tb/tb_stack_machine_executor_core.sv]
// Testbench top for the stack machine executor: drives compiled words and result backpressure.
// Depends on smx_pkg, stack_machine_executor_core and smx_result_checker.
`timescale 1ns / 1ps

module tb_stack_machine_executor_core
	import smx_pkg::*;
();

	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_WORDS = 430;

	typedef enum int {GEN_MIX, GEN_FILL, GEN_DRAIN} gen_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // literal_value[31:0]
	logic [3:0]  s_tuser;   // opcode[3:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // emit_char[7:0], stack_depth[15:8], top_of_stack[47:16]
	logic [2:0]  m_tuser;   // status[1:0], emit_valid[2]

	int mismatches, pending, model_depth, words_seen, results_seen;
	int underflows, overflows, div_zeros, emits;

	int        send_idle_pct = 8;
	int        rx_idle_pct   = 81;
	logic      hold_req      = 1'b0;
	logic      hold_rx;
	int        depth_guess   = 0;
	int        limit_tries   = 0;
	gen_mode_t gen_mode      = GEN_MIX;

	stack_machine_executor_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	smx_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.mismatches   (mismatches),
		.pending      (pending),
		.model_depth  (model_depth),
		.words_seen   (words_seen),
		.results_seen (results_seen),
		.underflows   (underflows),
		.overflows    (overflows),
		.div_zeros    (div_zeros),
		.emits        (emits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result backpressure: random stalls, or a solid hold while hold_rx is set
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Long receiver hold-off, counted here once requested
	initial begin
		hold_rx = 1'b0;
		wait (hold_req);
		hold_rx = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb_stack_machine_executor_core NOT OK");
		$finish;
	end

	// Mix of extremes, small values (for zero divisors and equal operands) and noise
	function automatic logic [31:0] pick_literal();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'd0;
			3:       return 32'hFFFF_FFFF;
			4, 5:    return $urandom_range(16) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Offer one word with random idle cycles ahead of it, return once accepted
	task automatic send_word(input logic [3:0] op, input logic [31:0] lit);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= lit;
		@(posedge clk);
		while (!s_tready) @(posedge clk);

		// Rough depth estimate used only to steer the generator
		if (op == OP_PUSH) begin
			if (depth_guess < STACK_DEPTH) depth_guess++;
		end else if (op == OP_DUP) begin
			if (depth_guess >= 1 && depth_guess < STACK_DEPTH) depth_guess++;
		end else if (op >= OP_ADD && op <= OP_EQ) begin
			if (depth_guess >= 2) depth_guess--;
		end else if (op == OP_DROP || op == OP_EMIT) begin
			if (depth_guess >= 1) depth_guess--;
		end
	endtask

	// Stop offering words until every result is back, then resync the estimate
	task automatic pause_until_done();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		depth_guess = model_depth;
		@(posedge clk);
	endtask

	task automatic run_random(input int count);
		logic [3:0]  op;
		logic [31:0] lit;
		int          r, push_w;
		for (int i = 0; i < count; i++) begin
			lit = $urandom;
			case (gen_mode)
				// Push to the top and a few words past it
				GEN_FILL: begin
					op = ($urandom_range(3) == 0 && depth_guess > 0) ? OP_DUP : OP_PUSH;
					if (op == OP_PUSH) lit = pick_literal();
					if (depth_guess >= STACK_DEPTH) begin
						limit_tries++;
						if (limit_tries >= 3) begin
							gen_mode    = GEN_DRAIN;
							limit_tries = 0;
						end
					end
				end
				// Consume down to empty and a few words beyond
				GEN_DRAIN: begin
					if ($urandom_range(2) == 0)
						op = 4'($urandom_range(OP_ADD, OP_EQ));
					else
						op = 4'($urandom_range(OP_DROP, OP_EMIT));
					if (depth_guess == 0) begin
						limit_tries++;
						if (limit_tries >= 3) begin
							gen_mode    = GEN_MIX;
							limit_tries = 0;
						end
					end
				end
				default: begin
					push_w = (depth_guess < 3) ? 55 : (depth_guess > 24) ? 15 : 30;
					r = $urandom_range(99);
					if (r < 3) begin
						op = 4'($urandom_range(14, 15));
					end else if (r < 3 + push_w) begin
						op  = OP_PUSH;
						lit = pick_literal();
					end else if (r < 3 + push_w + (97 - push_w) * 2 / 3) begin
						op = 4'($urandom_range(OP_ADD, OP_EQ));
					end else begin
						op = 4'($urandom_range(OP_DUP, OP_EMIT));
					end
				end
			endcase
			send_word(op, lit);
		end
	endtask

	initial begin : stimulus
		int guard;
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 32'd0;
		s_tuser  <= OP_PUSH;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Underflow on an empty stack
		send_word(OP_DROP, 32'hFFFF_FFFF);
		send_word(OP_ADD,  32'h0);
		send_word(OP_SWAP, 32'h0);
		send_word(OP_DUP,  32'h0);
		send_word(OP_EMIT, 32'h0);
		// Most negative value divided by minus one wraps
		send_word(OP_PUSH, 32'hFFFF_FFFF);
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_DIV,  32'h0);
		send_word(OP_PUSH, 32'h7FFF_FFFF);
		send_word(OP_ADD,  32'h0);
		// Zero divisor consumes both operands
		send_word(OP_PUSH, 32'h0);
		send_word(OP_SWAP, 32'h0);
		send_word(OP_DIV,  32'h0);
		// Comparisons across the signed extremes
		send_word(OP_PUSH, 32'h7FFF_FFFF);
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_LT,   32'h0);
		send_word(OP_DUP,  32'h0);
		send_word(OP_LE,   32'h0);
		send_word(OP_DUP,  32'h0);
		send_word(OP_GT,   32'h0);
		send_word(OP_DUP,  32'h0);
		send_word(OP_GE,   32'h0);
		send_word(OP_PUSH, 32'h0000_01FF);
		send_word(OP_SUB,  32'h0);
		send_word(OP_DUP,  32'h0);
		send_word(OP_MUL,  32'h0);
		send_word(OP_EQ,   32'h0);
		send_word(OP_EMIT, 32'h0);
		send_word(4'd14,   32'h0);
		send_word(4'd15,   32'h0);
		pause_until_done();

		// Sender mostly busy, receiver mostly stalled; starts with a fill
		gen_mode = GEN_FILL;
		run_random(PHASE_WORDS);
		pause_until_done();

		// Sender mostly idle, receiver mostly ready
		send_idle_pct = 81;
		rx_idle_pct   = 8;
		run_random(PHASE_WORDS);
		pause_until_done();

		// No idling; long receiver hold-off while words keep coming, then a fill
		send_idle_pct = 0;
		rx_idle_pct   = 0;
		run_random(100);
		hold_req = 1'b1;
		run_random(60);
		gen_mode = GEN_FILL;
		run_random(PHASE_WORDS - 160);
		s_tvalid <= 1'b0;

		// Wait out the last results, then allow for a trailing divide
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		@(negedge clk);

		$display("Ran %0d words, %0d results back: %0d underflow, %0d overflow,",
			words_seen, results_seen, underflows, overflows);
		$display("%0d divide-by-zero, %0d emitted characters, %0d mismatches, %0d outstanding",
			div_zeros, emits, mismatches, pending);
		if (mismatches == 0 && pending == 0)
			$display("tb_stack_machine_executor_core OK");
		else
			$display("tb_stack_machine_executor_core NOT OK");
		$finish;
	end

endmodule

[stack_machine_executor_core.f]
src/smx_pkg.sv
src/smx_div.sv
src/smx_dpath.sv
src/smx_ctrl.sv
src/stack_machine_executor_core.sv
tb/smx_result_checker.sv
tb/tb_stack_machine_executor_core.sv
